// File: hw/rtl/biou_pkg.sv
// ----------------------------------------------------------------------------
// Box IoU package
// Field widths and derived datapath widths shared by the IoU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

	// Box coordinates are two's complement, sizes are unsigned.
	localparam int COORD_W = 14;
	localparam int SIZE_W  = 13;

	// Default number of fraction bits of the result.
	localparam int IOU_FRAC_BITS_DEF = 16;

	// A right or bottom edge is a coordinate plus a size.
	localparam int EDGE_W = COORD_W + 1;
	// Per-axis overlap, signed, wide enough for the most negative gap.
	localparam int OVL_W  = COORD_W + 2;
	// A size plus one, up to 2**SIZE_W.
	localparam int EXT_W  = SIZE_W + 1;
	// A box area, up to 2**(2*SIZE_W).
	localparam int AREA_W = 2 * SIZE_W + 1;
	// The union, up to twice the largest area.
	localparam int UNION_W = AREA_W + 1;

endpackage

`default_nettype wire

// File: hw/rtl/box_iou_inclusive_unit.sv
// ----------------------------------------------------------------------------
// Box IoU unit
// Intersection over union of two axis-aligned boxes with inclusive end
// pixels, as a truncated unsigned fraction with IOU_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// The result passes four front stages and one restoring division step per
// quotient bit. Throughput: one box pair per cycle; a stall on the output
// freezes the whole pipeline. Reset clears all valid bits; data is not reset.
`default_nettype none

module box_iou_inclusive_unit #(
	parameter int IOU_FRAC_BITS = biou_pkg::IOU_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [biou_pkg::COORD_W-1:0]   left_a,
	input  wire logic signed [biou_pkg::COORD_W-1:0]   top_a,
	input  wire logic        [biou_pkg::SIZE_W-1:0]    width_a,
	input  wire logic        [biou_pkg::SIZE_W-1:0]    height_a,
	input  wire logic signed [biou_pkg::COORD_W-1:0]   left_b,
	input  wire logic signed [biou_pkg::COORD_W-1:0]   top_b,
	input  wire logic        [biou_pkg::SIZE_W-1:0]    width_b,
	input  wire logic        [biou_pkg::SIZE_W-1:0]    height_b,

	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic             [IOU_FRAC_BITS:0]         iou
);

	localparam int COORD_W = biou_pkg::COORD_W;
	localparam int EDGE_W  = biou_pkg::EDGE_W;
	localparam int OVL_W   = biou_pkg::OVL_W;
	localparam int EXT_W   = biou_pkg::EXT_W;
	localparam int AREA_W  = biou_pkg::AREA_W;
	localparam int UNION_W = biou_pkg::UNION_W;
	localparam int QUO_W   = IOU_FRAC_BITS + 1;
	localparam int NDIV    = IOU_FRAC_BITS + 1;

	// The whole pipeline moves together whenever the output can drain.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// ------------------------------------------------------------------
	// Stage 1: edges, nearest right/bottom, farthest left/top and box extents.
	// ------------------------------------------------------------------
	logic signed [EDGE_W-1:0]  rgt_a, rgt_b, bot_a, bot_b;
	logic                      vld_s1;
	logic signed [EDGE_W-1:0]  min_r_s1, min_b_s1;
	logic signed [COORD_W-1:0] max_l_s1, max_t_s1;
	logic        [EXT_W-1:0]   wa1_s1, ha1_s1, wb1_s1, hb1_s1;

	assign rgt_a = $signed({left_a[COORD_W-1], left_a}) + $signed({2'b00, width_a});
	assign rgt_b = $signed({left_b[COORD_W-1], left_b}) + $signed({2'b00, width_b});
	assign bot_a = $signed({top_a[COORD_W-1], top_a}) + $signed({2'b00, height_a});
	assign bot_b = $signed({top_b[COORD_W-1], top_b}) + $signed({2'b00, height_b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			min_r_s1 <= (rgt_a < rgt_b) ? rgt_a : rgt_b;
			min_b_s1 <= (bot_a < bot_b) ? bot_a : bot_b;
			max_l_s1 <= (left_a > left_b) ? left_a : left_b;
			max_t_s1 <= (top_a > top_b) ? top_a : top_b;
			wa1_s1   <= {1'b0, width_a} + EXT_W'(1);
			ha1_s1   <= {1'b0, height_a} + EXT_W'(1);
			wb1_s1   <= {1'b0, width_b} + EXT_W'(1);
			hb1_s1   <= {1'b0, height_b} + EXT_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: per-axis overlap and the two box areas.
	// ------------------------------------------------------------------
	logic                     vld_s2;
	logic signed [OVL_W-1:0]  ow_s2, oh_s2;
	logic        [AREA_W-1:0] area_a_s2, area_b_s2;
	logic        [2*EXT_W-1:0] prod_a, prod_b;

	assign prod_a = wa1_s1 * ha1_s1;
	assign prod_b = wb1_s1 * hb1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ow_s2 <= $signed({min_r_s1[EDGE_W-1], min_r_s1})
				- $signed({{2{max_l_s1[COORD_W-1]}}, max_l_s1}) + OVL_W'(1);
			oh_s2 <= $signed({min_b_s1[EDGE_W-1], min_b_s1})
				- $signed({{2{max_t_s1[COORD_W-1]}}, max_t_s1}) + OVL_W'(1);
			area_a_s2 <= prod_a[AREA_W-1:0];
			area_b_s2 <= prod_b[AREA_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: intersection (zero when the boxes miss) and area sum.
	// ------------------------------------------------------------------
	logic                      hit;
	logic        [2*EXT_W-1:0] prod_i;
	logic                      vld_s3;
	logic        [AREA_W-1:0]  inter_s3;
	logic        [UNION_W-1:0] sum_s3;

	assign hit    = !ow_s2[OVL_W-1] && (ow_s2 != '0) && !oh_s2[OVL_W-1] && (oh_s2 != '0);
	// A positive overlap never exceeds a box extent, so it fits EXT_W bits.
	assign prod_i = ow_s2[EXT_W-1:0] * oh_s2[EXT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inter_s3 <= hit ? prod_i[AREA_W-1:0] : '0;
			sum_s3   <= {1'b0, area_a_s2} + {1'b0, area_b_s2};
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: union. The dividend is the intersection, never above it.
	// ------------------------------------------------------------------
	logic                 vld_s4;
	logic [UNION_W-1:0]   uni_s4, rem_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uni_s4 <= sum_s3 - {1'b0, inter_s3};
			rem_s4 <= {1'b0, inter_s3};
		end
	end

	// ------------------------------------------------------------------
	// Division stages: one restoring step per quotient bit, MSB first.
	// The first step takes no shift and yields the integer bit, which is
	// set only when intersection equals union.
	// ------------------------------------------------------------------
	logic [UNION_W-1:0] div_rem_s [NDIV];
	logic [UNION_W-1:0] div_den_s [NDIV];
	logic [QUO_W-1:0]   div_quo_s [NDIV];
	logic [NDIV-1:0]    div_vld_s;

	logic [UNION_W-1:0] trial   [NDIV];
	logic [UNION_W-1:0] den_in  [NDIV];
	logic [QUO_W-1:0]   quo_in  [NDIV];
	logic [NDIV-1:0]    vld_in;
	logic [NDIV-1:0]    qbit;

	always_comb begin
		for (int k = 0; k < NDIV; k++) begin
			if (k == 0) begin
				trial[k]  = rem_s4;
				den_in[k] = uni_s4;
				quo_in[k] = '0;
				vld_in[k] = vld_s4;
			end else begin
				// The remainder stays below the union, so the shift loses nothing.
				trial[k]  = {div_rem_s[k-1][UNION_W-2:0], 1'b0};
				den_in[k] = div_den_s[k-1];
				quo_in[k] = div_quo_s[k-1];
				vld_in[k] = div_vld_s[k-1];
			end
			qbit[k] = (trial[k] >= den_in[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
		end else if (adv) begin
			div_vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NDIV; k++) begin
				div_rem_s[k] <= qbit[k] ? (trial[k] - den_in[k]) : trial[k];
				div_den_s[k] <= den_in[k];
				div_quo_s[k] <= {quo_in[k][QUO_W-2:0], qbit[k]};
			end
		end
	end

	assign out_valid = div_vld_s[NDIV-1];
	assign iou       = div_quo_s[NDIV-1];

`ifndef ASSERT_OFF
	// The union is at least one pixel for every pair of boxes.
	a_union_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (uni_s4 != '0))
		else $error("union is zero");

	// The intersection never exceeds the union.
	a_inter_le_union: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (rem_s4 <= uni_s4))
		else $error("intersection exceeds union");

	// Every step leaves a remainder below the divisor; the last step is checked.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (div_rem_s[NDIV-1] < div_den_s[NDIV-1]))
		else $error("division remainder out of range");

	// The result never exceeds one.
	a_iou_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && iou[IOU_FRAC_BITS] |-> (iou[IOU_FRAC_BITS-1:0] == '0))
		else $error("iou above one");
`endif

endmodule

`default_nettype wire
